[hdl/pbns_pkg.sv]
package pbns_pkg;

   localparam int COL_W     = 11;
   localparam int SPAN_W    = 12;
   localparam int ADDR_IN_W = 14;
   localparam int DATA_W    = 8;
   localparam int PROD_W    = COL_W + SPAN_W;
   localparam int QUO_W     = 11;
   localparam int POS_W     = 12;
   localparam int ROWB_W    = 9;
   localparam int BADDR_W   = POS_W + ROWB_W;
   localparam int BIT_W     = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int STORE_BYTES_DEF    = 16384;
   localparam int MAX_DIM            = 2048;
   localparam int RESET_BITMAP_WIDTH = 8;

   localparam logic [SPAN_W-1:0] MAX_DIM_V       = SPAN_W'(MAX_DIM);
   localparam logic [ROWB_W-1:0] RESET_ROW_BYTES = ROWB_W'((RESET_BITMAP_WIDTH + 7) / 8);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITMAP_WIDTH = 3'd0,
      CSR_SRC_LEFT     = 3'd1,
      CSR_SRC_TOP      = 3'd2,
      CSR_SRC_SPAN_X   = 3'd3,
      CSR_SRC_SPAN_Y   = 3'd4,
      CSR_DST_SPAN_X   = 3'd5,
      CSR_DST_SPAN_Y   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                 op;
      logic                 in_range;
      logic [COL_W-1:0]     col;
      logic [COL_W-1:0]     row;
      logic [ADDR_IN_W-1:0] addr;
      logic [DATA_W-1:0]    data;
   } item_type;

   function automatic logic [SPAN_W-1:0] sat_dim(input logic [SPAN_W-1:0] v);
      return (v > MAX_DIM_V) ? MAX_DIM_V : v;
   endfunction

   // bytes per padded row: ceil(width / 8)
   function automatic logic [ROWB_W-1:0] row_bytes_of(input logic [SPAN_W-1:0] w);
      logic [SPAN_W:0] s;
      s = {1'b0, w} + (SPAN_W + 1)'(7);
      return s[ROWB_W+2:3];
   endfunction

endpackage

[hdl/pbns_ram.sv]
module pbns_ram #(
   parameter int WIDTH = pbns_pkg::DATA_W,
   parameter int DEPTH = pbns_pkg::STORE_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[hdl/pbns_div_lane.sv]
// Restoring divider, one quotient bit per stage, MSB first.
// Quotient is known to fit in QUO_W bits for in-range queries.
module pbns_div_lane (
   input  logic                        clock,
   input  logic [pbns_pkg::QUO_W-1:0]  stage_en,
   input  logic [pbns_pkg::PROD_W-1:0] dividend,
   input  logic [pbns_pkg::SPAN_W-1:0] divisor,
   output logic [pbns_pkg::QUO_W-1:0]  quotient
);

   localparam int QW = pbns_pkg::QUO_W;
   localparam int PW = pbns_pkg::PROD_W;

   logic [PW-1:0] rem_ff [QW-1];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [PW-1:0] rem_prev;
      logic [QW-1:0] quo_prev;
      logic [PW-1:0] trial;
      logic          take;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = dividend;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign trial  = PW'(divisor) << (QW - 1 - k);
      assign take   = rem_prev >= trial;
      assign quo_in = {quo_prev[QW-2:0], take};

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            quo_ff[k] <= quo_in;
         end
      end

      // last remainder is not needed
      if (k < QW - 1) begin : g_rem
         logic [PW-1:0] rem_in;

         assign rem_in = take ? (rem_prev - trial) : rem_prev;

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

[hdl/packed_bitmap_nearest_scaler.sv]
// Throughput: one item per cycle; a stalled output only holds the stages that are full,
// so empty stages keep taking items. Writes use pipeline slots but give no result.
// The 11-stage divider lanes and the single bitmap store port set the pipeline depth.
// Reset (synchronous) clears all stage valid bits and the configuration registers but
// the bitmap width (set to RESET_BITMAP_WIDTH); the store holds garbage until written.
module packed_bitmap_nearest_scaler #(
   parameter int STORE_BYTES = pbns_pkg::STORE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata, low bit up: byte_address[13:0], byte_data[21:14], dest_col[32:22],
   // dest_row[43:33], zero pad[47:44]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,
   // req_tuser: op
   input  logic                            req_tuser,
   // rsp_tdata, low bit up: pixel_col[10:0], pixel_row[21:11], pixel_on[22],
   // query_valid[23]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [pbns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pbns_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW      = $clog2(STORE_BYTES);
   localparam int QW      = pbns_pkg::QUO_W;
   localparam int BW      = pbns_pkg::BADDR_W;
   localparam int S_POS   = 1 + QW;
   localparam int S_ROW   = S_POS + 1;
   localparam int S_ADR   = S_ROW + 1;
   localparam int S_OUT   = S_ADR + 1;
   localparam int NST     = S_OUT + 1;
   localparam logic [BW-1:0] STORE_LIM = BW'(STORE_BYTES);

   // configuration
   logic [pbns_pkg::ROWB_W-1:0] row_bytes_ff;
   logic [pbns_pkg::COL_W-1:0]  src_left_ff;
   logic [pbns_pkg::COL_W-1:0]  src_top_ff;
   logic [pbns_pkg::SPAN_W-1:0] src_span_x_ff;
   logic [pbns_pkg::SPAN_W-1:0] src_span_y_ff;
   logic [pbns_pkg::SPAN_W-1:0] dst_span_x_ff;
   logic [pbns_pkg::SPAN_W-1:0] dst_span_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff  <= pbns_pkg::RESET_ROW_BYTES;
         src_left_ff   <= '0;
         src_top_ff    <= '0;
         src_span_x_ff <= '0;
         src_span_y_ff <= '0;
         dst_span_x_ff <= '0;
         dst_span_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pbns_pkg::CSR_BITMAP_WIDTH: begin
               row_bytes_ff <= pbns_pkg::row_bytes_of(pbns_pkg::sat_dim(csr_wdata));
            end
            pbns_pkg::CSR_SRC_LEFT:   src_left_ff   <= csr_wdata[pbns_pkg::COL_W-1:0];
            pbns_pkg::CSR_SRC_TOP:    src_top_ff    <= csr_wdata[pbns_pkg::COL_W-1:0];
            pbns_pkg::CSR_SRC_SPAN_X: src_span_x_ff <= pbns_pkg::sat_dim(csr_wdata);
            pbns_pkg::CSR_SRC_SPAN_Y: src_span_y_ff <= pbns_pkg::sat_dim(csr_wdata);
            pbns_pkg::CSR_DST_SPAN_X: dst_span_x_ff <= pbns_pkg::sat_dim(csr_wdata);
            pbns_pkg::CSR_DST_SPAN_Y: dst_span_y_ff <= pbns_pkg::sat_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   // stage control: a stage loads when it is empty or the one after it moves
   logic [NST:0]   adv;
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;

   pbns_pkg::item_type          adr_item_ff;

   always_comb begin
      adv[NST] = rsp_tready;
      for (int i = NST - 1; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (adv[0]) begin
         v_in[0] = req_tvalid;
      end
      for (int i = 1; i < S_OUT; i++) begin
         if (adv[i]) begin
            v_in[i] = v_ff[i-1];
         end
      end
      // write items leave the pipe at the store
      if (adv[S_OUT]) begin
         v_in[S_OUT] = v_ff[S_ADR] && (adr_item_ff.op == pbns_pkg::OP_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = adv[0];

   // stage 0: unpack, range check, products
   pbns_pkg::item_type          req_item;
   pbns_pkg::item_type          item_ff [S_POS];
   logic [pbns_pkg::PROD_W-1:0] prod_x_ff;
   logic [pbns_pkg::PROD_W-1:0] prod_y_ff;
   logic [pbns_pkg::PROD_W-1:0] prod_x_in;
   logic [pbns_pkg::PROD_W-1:0] prod_y_in;

   always_comb begin
      req_item.op       = req_tuser;
      req_item.addr     = req_tdata[13:0];
      req_item.data     = req_tdata[21:14];
      req_item.col      = req_tdata[32:22];
      req_item.row      = req_tdata[43:33];
      // col < span also rules out an empty destination
      req_item.in_range = ({1'b0, req_item.col} < dst_span_x_ff) &&
                          ({1'b0, req_item.row} < dst_span_y_ff);
   end

   assign prod_x_in = pbns_pkg::PROD_W'(req_item.col) * pbns_pkg::PROD_W'(src_span_x_ff);
   assign prod_y_in = pbns_pkg::PROD_W'(req_item.row) * pbns_pkg::PROD_W'(src_span_y_ff);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         item_ff[0] <= req_item;
         prod_x_ff  <= prod_x_in;
         prod_y_ff  <= prod_y_in;
      end
      for (int i = 1; i < S_POS; i++) begin
         if (adv[i]) begin
            item_ff[i] <= item_ff[i-1];
         end
      end
   end

   // stages 1..QW: divide by destination span
   logic [QW-1:0] quot_x;
   logic [QW-1:0] quot_y;

   pbns_div_lane u_div_x (
      .clock    (clock),
      .stage_en (adv[QW:1]),
      .dividend (prod_x_ff),
      .divisor  (dst_span_x_ff),
      .quotient (quot_x)
   );

   pbns_div_lane u_div_y (
      .clock    (clock),
      .stage_en (adv[QW:1]),
      .dividend (prod_y_ff),
      .divisor  (dst_span_y_ff),
      .quotient (quot_y)
   );

   // source position
   pbns_pkg::item_type         pos_item_ff;
   logic [pbns_pkg::POS_W-1:0] pos_sx_ff;
   logic [pbns_pkg::POS_W-1:0] pos_sy_ff;

   always_ff @(posedge clock) begin
      if (adv[S_POS]) begin
         pos_item_ff <= item_ff[S_POS-1];
         pos_sx_ff   <= {1'b0, src_left_ff} + {1'b0, quot_x};
         pos_sy_ff   <= {1'b0, src_top_ff} + {1'b0, quot_y};
      end
   end

   // row offset
   pbns_pkg::item_type          row_item_ff;
   logic [BW-1:0]               row_prod_ff;
   logic [pbns_pkg::ROWB_W-1:0] row_sxb_ff;
   logic [pbns_pkg::BIT_W-1:0]  row_bit_ff;

   always_ff @(posedge clock) begin
      if (adv[S_ROW]) begin
         row_item_ff <= pos_item_ff;
         row_prod_ff <= BW'(pos_sy_ff) * BW'(row_bytes_ff);
         row_sxb_ff  <= pos_sx_ff[pbns_pkg::POS_W-1:pbns_pkg::BIT_W];
         row_bit_ff  <= pos_sx_ff[pbns_pkg::BIT_W-1:0];
      end
   end

   // store address: write address or mapped byte, bounds checked
   logic [BW-1:0]              acc_addr;
   logic                       acc_ok;
   logic [AW-1:0]              adr_addr_ff;
   logic                       adr_ok_ff;
   logic [pbns_pkg::BIT_W-1:0] adr_bit_ff;

   always_comb begin
      if (row_item_ff.op == pbns_pkg::OP_WRITE) begin
         acc_addr = BW'(row_item_ff.addr);
         acc_ok   = acc_addr < STORE_LIM;
      end else begin
         acc_addr = row_prod_ff + BW'(row_sxb_ff);
         acc_ok   = row_item_ff.in_range && (acc_addr < STORE_LIM);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[S_ADR]) begin
         adr_item_ff <= row_item_ff;
         adr_addr_ff <= acc_addr[AW-1:0];
         adr_ok_ff   <= acc_ok;
         adr_bit_ff  <= row_bit_ff;
      end
   end

   // store access and output register
   logic                        ram_we;
   logic                        ram_re;
   logic [pbns_pkg::DATA_W-1:0] ram_rdata;
   logic [pbns_pkg::COL_W-1:0]  out_col_ff;
   logic [pbns_pkg::COL_W-1:0]  out_row_ff;
   logic                        out_valid_ff;
   logic [pbns_pkg::BIT_W-1:0]  out_bit_ff;
   logic                        pixel_on;

   assign ram_we = adv[S_OUT] && v_ff[S_ADR] && adr_ok_ff &&
                   (adr_item_ff.op == pbns_pkg::OP_WRITE);
   assign ram_re = adv[S_OUT] && v_ff[S_ADR] && adr_ok_ff &&
                   (adr_item_ff.op == pbns_pkg::OP_QUERY);

   pbns_ram #(
      .WIDTH (pbns_pkg::DATA_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (adr_addr_ff),
      .wdata (adr_item_ff.data),
      .re    (ram_re),
      .raddr (adr_addr_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (adv[S_OUT]) begin
         out_col_ff   <= adr_item_ff.col;
         out_row_ff   <= adr_item_ff.row;
         out_valid_ff <= adr_ok_ff;
         out_bit_ff   <= adr_bit_ff;
      end
   end

   // MSB of a byte is its leftmost pixel
   assign pixel_on   = out_valid_ff && ram_rdata[3'd7 - out_bit_ff];
   assign rsp_tvalid = v_ff[S_OUT];
   assign rsp_tdata  = {out_valid_ff, pixel_on, out_row_ff, out_col_ff};

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store written and read in the same cycle");

   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> v_ff[S_OUT])
      else $error("store read without a result slot");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (adv[S_OUT] && v_ff[S_ADR] && (adr_item_ff.op == pbns_pkg::OP_WRITE))
      |=> !v_ff[S_OUT])
      else $error("write item produced a result");

   // store data of an invalid result may never have been read, so watch pixel_on
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[S_OUT] && !rsp_tready) |=>
      ($stable(out_col_ff) && $stable(out_row_ff) && $stable(pixel_on) &&
       $stable(out_valid_ff)))
      else $error("stalled result changed");

endmodule

[verif/packed_bitmap_nearest_scaler_tb.sv]
`timescale 1ns / 1ps

module packed_bitmap_nearest_scaler_tb;
   import pbns_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int PIPE_SETTLE   = 24;     // covers the block latency, plus margin
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PRINT_LIMIT   = 100;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;   // index past the register list

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] row;
      logic             on;
      logic             valid;
   } pixel_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;    // byte_address, byte_data, dest_col, dest_row, pad
   logic                  req_tuser;    // op
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;    // pixel_col, pixel_row, pixel_on, query_valid
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the block's configuration and bitmap
   logic [SPAN_W-1:0]  cfg_bitmap_width;
   logic [COL_W-1:0]   cfg_src_left;
   logic [COL_W-1:0]   cfg_src_top;
   logic [SPAN_W-1:0]  cfg_src_span_x;
   logic [SPAN_W-1:0]  cfg_src_span_y;
   logic [SPAN_W-1:0]  cfg_dst_span_x;
   logic [SPAN_W-1:0]  cfg_dst_span_y;
   logic [DATA_W-1:0]  shadow_bitmap  [0:STORE_BYTES_DEF-1];
   bit                 shadow_written [0:STORE_BYTES_DEF-1];

   pixel_result_type pending_pixels[$];
   int            error_count;
   int            cycle_count;
   int            burst_left;
   int            hold_request;
   int            hold_left;
   int            stall_mode;
   int            stall_mode_left;

   packed_bitmap_nearest_scaler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Map a destination pixel to its source byte; ok is the query_valid the block should give.
   function automatic void map_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                                     output bit ok, output logic [BADDR_W-1:0] baddr,
                                     output logic [BIT_W-1:0] bitpos);
      logic [PROD_W-1:0]  qx;
      logic [PROD_W-1:0]  qy;
      logic [POS_W-1:0]   sx;
      logic [POS_W-1:0]   sy;
      logic [ROWB_W-1:0]  rb;
      ok     = cfg_dst_span_x != 0 && cfg_dst_span_y != 0 &&
               SPAN_W'(col) < cfg_dst_span_x && SPAN_W'(row) < cfg_dst_span_y;
      baddr  = '0;
      bitpos = '0;
      if (ok) begin
         qx = (PROD_W'(col) * PROD_W'(cfg_src_span_x)) / PROD_W'(cfg_dst_span_x);
         qy = (PROD_W'(row) * PROD_W'(cfg_src_span_y)) / PROD_W'(cfg_dst_span_y);
         sx = POS_W'(cfg_src_left) + POS_W'(qx);
         sy = POS_W'(cfg_src_top) + POS_W'(qy);
         rb = ROWB_W'(((SPAN_W + 1)'(cfg_bitmap_width) + (SPAN_W + 1)'(7)) / 8);
         baddr  = BADDR_W'(sy) * BADDR_W'(rb) + BADDR_W'(sx >> 3);
         bitpos = sx[BIT_W-1:0];
         if (baddr >= BADDR_W'(STORE_BYTES_DEF))
            ok = 1'b0;
      end
   endfunction

   // Apply one accepted item to the shadow state and queue its pixel result.
   function automatic void predict_pixel(input logic op, input logic [ADDR_IN_W-1:0] addr,
                                         input logic [DATA_W-1:0] data,
                                         input logic [COL_W-1:0] col,
                                         input logic [COL_W-1:0] row);
      pixel_result_type   res;
      bit                 ok;
      logic [BADDR_W-1:0] baddr;
      logic [BIT_W-1:0]   bitpos;
      if (op == OP_WRITE) begin
         shadow_bitmap[addr]  = data;
         shadow_written[addr] = 1'b1;
      end else begin
         map_pixel(col, row, ok, baddr, bitpos);
         res.col   = col;
         res.row   = row;
         res.valid = ok;
         res.on    = ok ? shadow_bitmap[baddr][3'd7 - bitpos] : 1'b0;
         pending_pixels.push_back(res);
      end
   endfunction

   function automatic logic [SPAN_W-1:0] saturate_dim(input logic [SPAN_W-1:0] v);
      return (v > SPAN_W'(MAX_DIM)) ? SPAN_W'(MAX_DIM) : v;
   endfunction

   // registers change only with the block drained and the sender idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_BITMAP_WIDTH: cfg_bitmap_width = saturate_dim(v);
         CSR_SRC_LEFT:     cfg_src_left     = v[COL_W-1:0];
         CSR_SRC_TOP:      cfg_src_top      = v[COL_W-1:0];
         CSR_SRC_SPAN_X:   cfg_src_span_x   = saturate_dim(v);
         CSR_SRC_SPAN_Y:   cfg_src_span_y   = saturate_dim(v);
         CSR_DST_SPAN_X:   cfg_dst_span_x   = saturate_dim(v);
         CSR_DST_SPAN_Y:   cfg_dst_span_y   = saturate_dim(v);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] width,
                               input logic [CSR_DATA_W-1:0] left,
                               input logic [CSR_DATA_W-1:0] top,
                               input logic [CSR_DATA_W-1:0] sx, input logic [CSR_DATA_W-1:0] sy,
                               input logic [CSR_DATA_W-1:0] dx, input logic [CSR_DATA_W-1:0] dy);
      write_reg(CSR_BITMAP_WIDTH, width);
      write_reg(CSR_SRC_LEFT, left);
      write_reg(CSR_SRC_TOP, top);
      write_reg(CSR_SRC_SPAN_X, sx);
      write_reg(CSR_SRC_SPAN_Y, sy);
      write_reg(CSR_DST_SPAN_X, dx);
      write_reg(CSR_DST_SPAN_Y, dy);
   endtask

   // Offer one item, idling between bursts; returns once it is accepted.
   task automatic send_item(input logic op, input logic [ADDR_IN_W-1:0] addr,
                            input logic [DATA_W-1:0] data, input logic [COL_W-1:0] col,
                            input logic [COL_W-1:0] row);
      int gap;
      int pick;
      if (burst_left == 0) begin
         pick = $urandom_range(0, 19);
         gap  = (pick < 7) ? 0 : (pick < 16) ? $urandom_range(1, 3) : $urandom_range(4, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, row, col, data, addr};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_pixel(op, addr, data, col, row);
   endtask

   task automatic write_byte(input logic [ADDR_IN_W-1:0] addr, input logic [DATA_W-1:0] data);
      send_item(OP_WRITE, addr, data, COL_W'($urandom), COL_W'($urandom));
   endtask

   // A never-written source byte must not be read, so load it first.
   task automatic query_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
      bit                 ok;
      logic [BADDR_W-1:0] baddr;
      logic [BIT_W-1:0]   bitpos;
      map_pixel(col, row, ok, baddr, bitpos);
      if (ok && !shadow_written[baddr])
         write_byte(ADDR_IN_W'(baddr), DATA_W'($urandom));
      send_item(OP_QUERY, ADDR_IN_W'($urandom), DATA_W'($urandom), col, row);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic random_query();
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] row;
      if ($urandom_range(0, 9) < 8 && cfg_dst_span_x != 0 && cfg_dst_span_y != 0) begin
         col = COL_W'($urandom_range(0, int'(cfg_dst_span_x) - 1));
         row = COL_W'($urandom_range(0, int'(cfg_dst_span_y) - 1));
      end else begin
         col = COL_W'($urandom);
         row = COL_W'($urandom);
      end
      query_pixel(col, row);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_span();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;                    // saturates
         2:       return CSR_DATA_W'($urandom_range(0, 4095));
         default: return CSR_DATA_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_origin();
      case ($urandom_range(0, 7))
         0:       return CSR_DATA_W'(2047);
         1:       return CSR_DATA_W'($urandom_range(0, 2047));
         default: return CSR_DATA_W'($urandom_range(0, 30));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      // destination spans reset to zero: everything invalid
      write_byte('0, 8'hFF);
      write_byte('1, 8'h00);
      query_pixel('0, '0);
      query_pixel('1, '1);
      wait_idle();
   endtask

   task automatic test_empty_destination();
      set_geometry(16, 0, 0, 8, 8, 0, 8);
      query_pixel(0, 0);
      query_pixel(3, 5);
      write_reg(CSR_DST_SPAN_X, 8);
      write_reg(CSR_DST_SPAN_Y, 0);
      query_pixel(0, 0);
      wait_idle();
   endtask

   task automatic test_saturation_and_store_limit();
      // oversize values clamp; far source origin pushes the byte past the store
      set_geometry('1, 2047, 2047, '1, '1, '1, '1);
      write_reg(CSR_NO_REG, '1);
      query_pixel(0, 0);
      query_pixel('1, '1);
      write_reg(CSR_SRC_TOP, 0);
      write_reg(CSR_SRC_LEFT, 0);
      query_pixel('1, 0);
      query_pixel(0, 63);
      query_pixel(0, 64);
      wait_idle();
   endtask

   task automatic test_mapping_corners();
      set_geometry(13, 3, 2, 7, 5, 20, 3);
      query_pixel(0, 0);
      query_pixel(19, 0);
      query_pixel(0, 2);
      query_pixel(19, 2);
      query_pixel(20, 0);     // just outside in x
      query_pixel(0, 3);      // just outside in y
      wait_idle();
   endtask

   task automatic test_zero_bitmap_width();
      set_geometry(0, 5, 9, 16, 16, 4, 4);
      query_pixel(0, 0);
      query_pixel(3, 3);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      int i;
      set_geometry(24, 2, 1, 20, 12, 10, 10);
      hold_request = 300;
      for (i = 0; i < 80; i++) random_query();
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int phase;
      int i;
      int pick;
      bit ok;
      logic [BADDR_W-1:0] baddr;
      logic [BIT_W-1:0]   bitpos;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         if (phase == RANDOM_PHASES - 1)
            set_geometry(CSR_DATA_W'(MAX_DIM), 0, 0, CSR_DATA_W'(MAX_DIM),
                         CSR_DATA_W'(MAX_DIM), CSR_DATA_W'(MAX_DIM), CSR_DATA_W'(MAX_DIM));
         else
            set_geometry(($urandom_range(0, 3) == 0) ? pick_span() :
                            CSR_DATA_W'($urandom_range(1, 64)),
                         pick_origin(), pick_origin(), pick_span(), pick_span(),
                         pick_span(), pick_span());
         for (i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 3 && cfg_dst_span_x != 0 && cfg_dst_span_y != 0) begin
               // overwrite a byte that queries actually reach
               map_pixel(COL_W'($urandom_range(0, int'(cfg_dst_span_x) - 1)),
                         COL_W'($urandom_range(0, int'(cfg_dst_span_y) - 1)),
                         ok, baddr, bitpos);
               if (ok)
                  write_byte(ADDR_IN_W'(baddr), DATA_W'($urandom));
               else
                  random_query();
            end else if (pick < 5) begin
               write_byte(ADDR_IN_W'($urandom), DATA_W'($urandom));
            end else begin
               random_query();
            end
         end
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[10:0] !== want.col)
               report_error($sformatf("pixel_col %0d, want %0d", rsp_tdata[10:0], want.col));
            if (rsp_tdata[21:11] !== want.row)
               report_error($sformatf("pixel_row %0d, want %0d", rsp_tdata[21:11], want.row));
            if (rsp_tdata[22] !== want.on)
               report_error($sformatf("pixel_on %b, want %b at (%0d,%0d)",
                                      rsp_tdata[22], want.on, want.col, want.row));
            if (rsp_tdata[23] !== want.valid)
               report_error($sformatf("query_valid %b, want %b at (%0d,%0d)",
                                      rsp_tdata[23], want.valid, want.col, want.row));
         end
      end
   end

   // receiver: changing stall patterns, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(10, 80);
         end
         stall_mode_left--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 9) < 7);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = OP_WRITE;
      rsp_tready       = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_BITMAP_WIDTH;
      csr_wdata        = '0;
      error_count      = 0;
      cycle_count      = 0;
      burst_left       = 0;
      hold_request     = 0;
      hold_left        = 0;
      stall_mode       = 0;
      stall_mode_left  = 0;
      cfg_bitmap_width = SPAN_W'(RESET_BITMAP_WIDTH);
      cfg_src_left     = '0;
      cfg_src_top      = '0;
      cfg_src_span_x   = '0;
      cfg_src_span_y   = '0;
      cfg_dst_span_x   = '0;
      cfg_dst_span_y   = '0;
      for (int a = 0; a < STORE_BYTES_DEF; a++) begin
         shadow_bitmap[a]  = '0;
         shadow_written[a] = 1'b0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_empty_destination();
      test_saturation_and_store_limit();
      test_mapping_corners();
      test_zero_bitmap_width();
      test_output_backpressure();
      test_random_traffic();

      if (pending_pixels.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_pixels.size()));
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
hdl/pbns_pkg.sv
hdl/pbns_ram.sv
hdl/pbns_div_lane.sv
hdl/packed_bitmap_nearest_scaler.sv
verif/packed_bitmap_nearest_scaler_tb.sv
